// File: hw/rtl/bkt_pkg.sv
// ----------------------------------------------------------------------------
// bkt_pkg: shared definitions for the bucketed key table
// Default sizes, operation and result codes, controller states and the
// command and status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bkt_pkg;

  localparam int unsigned KEY_W            = 32;
  localparam int unsigned PAYLOAD_W        = 32;
  localparam int unsigned NUM_BUCKETS_DEF  = 256;
  localparam int unsigned BUCKET_DEPTH_DEF = 8;
  localparam int unsigned DATA_BITS_DEF    = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_ZERO_DATA = 2'd2,
    RES_FULL      = 2'd3
  } res_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_FILL_RD,
    S_FILL_WAIT,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic fill_rd;
    logic fill_latch;
    logic scan_start;
    logic scan_run;
    logic shift_start;
    logic shift_run;
    logic ins_write;
    logic fill_dec;
    logic clr_run;
    logic res_load;
    res_e res_code;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic mod_done;
    logic payload_zero;
    logic bucket_full;
    logic hit;
    logic scan_miss;
    logic shift_done;
    logic clr_done;
  } sts_t;

endpackage

// File: hw/rtl/bucketed_key_table.sv
// ----------------------------------------------------------------------------
// bucketed_key_table: keyed table of ordered buckets
// Insert appends a key/data entry to the bucket chosen by the key; find and
// delete scan that bucket in either direction, and delete closes the gap.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   -------  ---------  ---------------------  ------------------------------
//   input    in         in_valid_i/in_ready_o  op_i, key_i, payload_i,
//                                              backward_i
//   output   out        out_valid_o/out_ready_i status_o, found_payload_o
//
// Each request gives one result transfer. A find scans the bucket for the
// key; a delete scans it and then shifts each later entry one place lower.
// A bucket count that is not a power of two adds a step for the key
// remainder. Reset clears the fill memory before the first request is
// taken; a held result does not block the next request.
//
module bucketed_key_table #(
  parameter int unsigned NUM_BUCKETS  = bkt_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned BUCKET_DEPTH = bkt_pkg::BUCKET_DEPTH_DEF,
  parameter int unsigned DATA_BITS    = bkt_pkg::DATA_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    op_i,
  input  logic [bkt_pkg::KEY_W-1:0]     key_i,
  input  logic [bkt_pkg::PAYLOAD_W-1:0] payload_i,
  input  logic                          backward_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [bkt_pkg::PAYLOAD_W-1:0] found_payload_o
);
  import bkt_pkg::*;

  // Commands flow from the sequencer to the datapath; status flows back.
  cmd_t cmd;
  sts_t sts;

  // The sequencer owns both handshakes and the output valid flag.
  bkt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath captures the request at its transfer and holds the result
  // fields in the output register until the next result replaces them.
  bkt_dp #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .DATA_BITS    (DATA_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op_i),
    .key_i           (key_i),
    .payload_i       (payload_i),
    .backward_i      (backward_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .status_o        (status_o),
    .found_payload_o (found_payload_o)
  );

endmodule

// File: hw/rtl/bkt_ram.sv
// ----------------------------------------------------------------------------
// bkt_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module bkt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bkt_ctrl.sv
// ----------------------------------------------------------------------------
// bkt_ctrl: sequencer for the bucketed key table
// Steps each operation through bucket selection, fill lookup, scan and
// shift, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module bkt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bkt_pkg::sts_t sts_i,
  output bkt_pkg::cmd_t cmd_o
);
  import bkt_pkg::*;

  state_e state_q, state_d;
  res_e   code_q, code_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      code_q      <= RES_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    code_d     = code_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd.clr_run = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts_i.mod_done) begin
          state_d = S_FILL_RD;
        end
      end
      S_FILL_RD: begin
        cmd.fill_rd = 1'b1;
        state_d     = S_FILL_WAIT;
      end
      S_FILL_WAIT: begin
        cmd.fill_latch = 1'b1;
        case (sts_i.op)
          OP_INSERT: begin
            state_d = S_FINISH;
            if (sts_i.payload_zero) begin
              code_d = RES_ZERO_DATA;
            end else if (sts_i.bucket_full) begin
              code_d = RES_FULL;
            end else begin
              cmd.ins_write = 1'b1;
              code_d        = RES_OK;
            end
          end
          OP_FIND, OP_DELETE: begin
            cmd.scan_start = 1'b1;
            state_d        = S_SCAN;
          end
          default: begin
            code_d  = RES_NOT_FOUND;
            state_d = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts_i.hit) begin
          if (sts_i.op == OP_FIND) begin
            code_d  = RES_OK;
            state_d = S_FINISH;
          end else begin
            cmd.shift_start = 1'b1;
            state_d         = S_SHIFT;
          end
        end else if (sts_i.scan_miss) begin
          code_d  = RES_NOT_FOUND;
          state_d = S_FINISH;
        end
      end
      S_SHIFT: begin
        cmd.shift_run = 1'b1;
        if (sts_i.shift_done) begin
          cmd.fill_dec = 1'b1;
          code_d       = RES_OK;
          state_d      = S_FINISH;
        end
      end
      S_FINISH: begin
        // The output register takes the result once its previous one is gone or being taken.
        if (!out_valid_q || out_ready_i) begin
          cmd.res_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd.res_code = code_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/bkt_dp.sv
// ----------------------------------------------------------------------------
// bkt_dp: datapath of the bucketed key table
// Holds the request, reduces the key to a bucket, keeps the fill and entry
// memories, runs the scan and shift pointers and the result register.
// ----------------------------------------------------------------------------
module bkt_dp #(
  parameter int unsigned NUM_BUCKETS  = bkt_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned BUCKET_DEPTH = bkt_pkg::BUCKET_DEPTH_DEF,
  parameter int unsigned DATA_BITS    = bkt_pkg::DATA_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [1:0]                     op_i,
  input  logic [bkt_pkg::KEY_W-1:0]      key_i,
  input  logic [bkt_pkg::PAYLOAD_W-1:0]  payload_i,
  input  logic                           backward_i,
  input  bkt_pkg::cmd_t                  cmd_i,
  output bkt_pkg::sts_t                  sts_o,
  output logic [1:0]                     status_o,
  output logic [bkt_pkg::PAYLOAD_W-1:0]  found_payload_o
);
  import bkt_pkg::*;

  localparam int unsigned BW      = $clog2(NUM_BUCKETS);
  localparam int unsigned POS_W   = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int unsigned FILL_W  = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned SLOTS   = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int unsigned SLOT_AW = $clog2(SLOTS);
  localparam int unsigned ENTRY_W = KEY_W + DATA_BITS;
  localparam bit          IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

  // Request registers.
  op_e                  op_q;
  logic [KEY_W-1:0]     key_q;
  logic [DATA_BITS-1:0] data_q;
  logic                 back_q;

  logic [BW-1:0]        bucket;
  logic                 mod_done;
  logic [SLOT_AW-1:0]   base_q;
  logic [FILL_W-1:0]    fill_q;

  // Scan and shift pointers.
  logic [FILL_W-1:0]    cnt_q;
  logic                 pend_q;
  logic [POS_W-1:0]     pend_pos_q;
  logic [FILL_W-1:0]    sh_idx_q;
  logic                 sh_pend_q;
  logic [POS_W-1:0]     sh_wpos_q;
  logic [BW-1:0]        clr_q;

  logic [PAYLOAD_W-1:0] found_q;
  res_e                 out_code_q;
  logic [PAYLOAD_W-1:0] out_found_q;

  // Memory ports.
  logic                 fill_we;
  logic [BW-1:0]        fill_waddr;
  logic [FILL_W-1:0]    fill_wdata;
  logic [FILL_W-1:0]    fill_rdata;
  logic                 ent_we;
  logic [SLOT_AW-1:0]   ent_waddr;
  logic [ENTRY_W-1:0]   ent_wdata;
  logic                 ent_re;
  logic [SLOT_AW-1:0]   ent_raddr;
  logic [ENTRY_W-1:0]   ent_rdata;

  logic                 hit;
  logic                 scan_issue;
  logic [FILL_W-1:0]    scan_pos;
  logic                 sh_issue;

  // Bucket selection: a mask for a power-of-two count, otherwise a
  // reciprocal multiplication in two steps. The first step forms the
  // quotient product, the second subtracts quotient times bucket count.
  if (IS_POW2) begin : g_mask
    assign bucket   = key_q[BW-1:0];
    assign mod_done = 1'b1;
  end else begin : g_rem
    localparam logic [KEY_W:0] RECIP = (KEY_W+1)'(
        ((64'd1 << (KEY_W + BW)) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));
    logic               phase_q;
    logic [2*KEY_W:0]   prod_q;
    logic [KEY_W-1:0]   quot;
    logic [BW-1:0]      rem_q;

    assign quot     = KEY_W'(prod_q >> (KEY_W + BW));
    assign bucket   = rem_q;
    assign mod_done = phase_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        phase_q <= 1'b0;
        prod_q  <= '0;
        rem_q   <= '0;
      end else if (cmd_i.load) begin
        phase_q <= 1'b0;
      end else if (cmd_i.mod_step) begin
        phase_q <= 1'b1;
        if (!phase_q) begin
          prod_q <= (2*KEY_W+1)'(key_q) * (2*KEY_W+1)'(RECIP);
        end else begin
          rem_q <= BW'(key_q - quot * KEY_W'(NUM_BUCKETS));
        end
      end
    end
  end

  assign hit        = pend_q && (ent_rdata[KEY_W-1:0] == key_q);
  assign scan_issue = (cnt_q < fill_q) && !hit;
  assign scan_pos   = back_q ? (fill_q - cnt_q - FILL_W'(1)) : cnt_q;
  assign sh_issue   = sh_idx_q < fill_q;

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(op_i);
      key_q   <= key_i;
      data_q  <= DATA_BITS'(payload_i);
      back_q  <= backward_i;
      found_q <= '0;
    end
    if (cmd_i.fill_rd) begin
      base_q <= SLOT_AW'(bucket) * SLOT_AW'(BUCKET_DEPTH);
    end
    if (cmd_i.fill_latch) begin
      fill_q <= fill_rdata;
    end
    if (cmd_i.scan_run && scan_issue) begin
      pend_pos_q <= scan_pos[POS_W-1:0];
    end
    if (cmd_i.scan_run && hit && (op_q == OP_FIND)) begin
      found_q <= PAYLOAD_W'(ent_rdata[ENTRY_W-1:KEY_W]);
    end
    if (cmd_i.shift_run && sh_issue) begin
      sh_wpos_q <= POS_W'(sh_idx_q - FILL_W'(1));
    end
    if (cmd_i.res_load) begin
      out_code_q  <= cmd_i.res_code;
      out_found_q <= found_q;
    end
  end

  // Control counters and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      sh_idx_q  <= '0;
      sh_pend_q <= 1'b0;
      clr_q     <= '0;
    end else begin
      if (cmd_i.clr_run) begin
        clr_q <= clr_q + BW'(1);
      end
      if (cmd_i.scan_start) begin
        cnt_q  <= '0;
        pend_q <= 1'b0;
      end else if (cmd_i.scan_run) begin
        pend_q <= scan_issue;
        if (scan_issue) begin
          cnt_q <= cnt_q + FILL_W'(1);
        end
      end
      if (cmd_i.shift_start) begin
        sh_idx_q  <= FILL_W'(pend_pos_q) + FILL_W'(1);
        sh_pend_q <= 1'b0;
      end else if (cmd_i.shift_run) begin
        sh_pend_q <= sh_issue;
        if (sh_issue) begin
          sh_idx_q <= sh_idx_q + FILL_W'(1);
        end
      end
    end
  end

  // Fill memory writes: clearing pass, insert and delete.
  always_comb begin
    fill_we    = 1'b0;
    fill_waddr = bucket;
    fill_wdata = '0;
    if (cmd_i.clr_run) begin
      fill_we    = 1'b1;
      fill_waddr = clr_q;
    end else if (cmd_i.ins_write) begin
      fill_we    = 1'b1;
      fill_wdata = fill_rdata + FILL_W'(1);
    end else if (cmd_i.fill_dec) begin
      fill_we    = 1'b1;
      fill_wdata = fill_q - FILL_W'(1);
    end
  end

  // Entry memory: the insert writes at the fill position; the shift writes
  // each entry it reads one place lower.
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = base_q + SLOT_AW'(fill_rdata[POS_W-1:0]);
    ent_wdata = {data_q, key_q};
    if (cmd_i.ins_write) begin
      ent_we = 1'b1;
    end else if (cmd_i.shift_run && sh_pend_q) begin
      ent_we    = 1'b1;
      ent_waddr = base_q + SLOT_AW'(sh_wpos_q);
      ent_wdata = ent_rdata;
    end
  end

  always_comb begin
    ent_re    = 1'b0;
    ent_raddr = base_q + SLOT_AW'(scan_pos[POS_W-1:0]);
    if (cmd_i.scan_run) begin
      ent_re = scan_issue;
    end else if (cmd_i.shift_run) begin
      ent_re    = sh_issue;
      ent_raddr = base_q + SLOT_AW'(sh_idx_q[POS_W-1:0]);
    end
  end

  bkt_ram #(
    .WIDTH (FILL_W),
    .DEPTH (NUM_BUCKETS)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (fill_waddr),
    .wdata_i (fill_wdata),
    .re_i    (cmd_i.fill_rd),
    .raddr_i (bucket),
    .rdata_o (fill_rdata)
  );

  bkt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  always_comb begin
    sts_o.op           = op_q;
    sts_o.mod_done     = mod_done;
    sts_o.payload_zero = (data_q == '0);
    sts_o.bucket_full  = (fill_rdata >= FILL_W'(BUCKET_DEPTH));
    sts_o.hit          = hit;
    sts_o.scan_miss    = !pend_q && (cnt_q == fill_q);
    sts_o.shift_done   = !sh_pend_q && !sh_issue;
    sts_o.clr_done     = (clr_q == BW'(NUM_BUCKETS - 1));
  end

  assign status_o        = out_code_q;
  assign found_payload_o = out_found_q;

endmodule
